[rtl/mcs_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and helper functions of the mixing cut separation block.
// Used by mcs_cell and mixing_cut_separation; no dependencies.
package mcs_pkg;

  localparam int MAX_ITEMS_DEF = 32;
  localparam int POS_W         = 6;
  localparam int INDEX_BITS    = 10;
  localparam int THR_W         = 32;
  localparam int Z_W           = 17;
  localparam int TOL_W         = 16;
  localparam int IN_TDATA_W    = 96;
  localparam int OUT_TDATA_W   = 112;

  localparam logic KIND_TERM    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic                         valid;
    logic [POS_W-1:0]             pos;
    logic signed [THR_W-1:0]      thr;
    logic [INDEX_BITS-1:0]        idx;
    logic [Z_W-1:0]               z;
  } entry_t;

  typedef struct packed {
    logic load;
    logic rotate;
    logic clear;
  } cell_ctrl_t;

  // Saturate a 33-bit signed difference to 32 bits.
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Saturate a 64-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7fff_ffff) begin
      r = 32'sh7fff_ffff;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/mcs_cell.sv]
`timescale 1ns / 1ps
// One cell of the sorted entry chain: holds one entry, inserts in order, rotates.
// Depends on mcs_pkg.
module mcs_cell (
  input  logic               clk,
  input  logic               rst,
  input  mcs_pkg::cell_ctrl_t ctrl,
  input  mcs_pkg::entry_t    new_entry,
  input  mcs_pkg::entry_t    up_entry,
  input  logic               up_before,
  input  mcs_pkg::entry_t    down_entry,
  output mcs_pkg::entry_t    entry,
  output logic               ahead
);

  // A newer entry has the larger position, so it wins a tie in z.
  assign ahead = !entry.valid || (new_entry.z >= entry.z);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (ctrl.clear) begin
      entry.valid <= 1'b0;
    end else if (ctrl.rotate) begin
      entry <= down_entry;
    end else if (ctrl.load && ahead) begin
      entry <= up_before ? up_entry : new_entry;
    end
  end

endmodule

[rtl/mixing_cut_separation.sv]
`timescale 1ns / 1ps
// Top level of the mixing cut separation block: entry chain, walk and cut output.
// Depends on mcs_pkg and mcs_cell.
//
//  channel   direction  handshake          contents
//  s_*       in         tvalid/tready      tdata: threshold, scen_index, z, y; tlast: last
//  m_*       out        tvalid/tready      tdata: index, coef, found, rhs, violation;
//                                          tuser: kind; tlast: end_of_run
//  cfg_*     in         we only            tolerance
//
// Loading accepts one entry per cycle; each entry, up to MAX_ITEMS, is inserted into the sorted
// chain on arrival. The last entry starts a rotation of the chain to total the cut, then the
// product pipeline drains and the compare runs; a found cut adds a second rotation that emits
// the terms, and the summary is loaded last.
// Reset is synchronous and clears the chain, the count and the output; tolerance returns to 1.
// Output stalls hold the second rotation; the input is not ready until the summary is loaded.
module mixing_cut_separation #(
  parameter int MAX_ITEMS = mcs_pkg::MAX_ITEMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [31:0] threshold_value, [41:32] scen_index, [58:42] z_value, [90:59] y_value
  input  logic [mcs_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [9:0] term_index, [41:10] term_coef, [42] cut_found, [74:43] cut_rhs, [106:75] violation
  output logic [mcs_pkg::OUT_TDATA_W-1:0] m_tdata,
  // [0] kind
  output logic                            m_tuser,
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [mcs_pkg::TOL_W-1:0]       cfg_wdata
);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_P1    = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_D1    = 3'd3;
  localparam logic [2:0] ST_D2    = 3'd4;
  localparam logic [2:0] ST_D3    = 3'd5;
  localparam logic [2:0] ST_P2    = 3'd6;
  localparam logic [2:0] ST_SUM   = 3'd7;

  localparam logic [mcs_pkg::POS_W-1:0] LAST_STEP = mcs_pkg::POS_W'(MAX_ITEMS - 1);
  localparam logic [mcs_pkg::POS_W-1:0] FULL     = mcs_pkg::POS_W'(MAX_ITEMS);

  logic [2:0]                       state;
  logic [mcs_pkg::POS_W-1:0]        cnt;
  logic [mcs_pkg::POS_W-1:0]        count;
  logic [mcs_pkg::TOL_W-1:0]        tol;
  logic signed [31:0]               y;
  logic signed [31:0]               thr0;
  logic signed [31:0]               thrp;
  logic [mcs_pkg::POS_W-1:0]        p;
  logic [mcs_pkg::POS_W-1:0]        m;
  logic signed [31:0]               thr_m;
  logic signed [31:0]               coef_r;
  logic [mcs_pkg::Z_W-1:0]          z_r;
  logic                             t1_v;
  logic signed [49:0]               prod_r;
  logic                             t2_v;
  logic signed [63:0]               lhs;
  logic signed [63:0]               rhs;
  logic signed [63:0]               acc_a;
  logic signed [63:0]               diff_d;
  logic                             found;
  logic signed [31:0]               viol;

  mcs_pkg::entry_t    cells [MAX_ITEMS];
  logic               bef   [MAX_ITEMS];
  mcs_pkg::entry_t    new_entry;
  mcs_pkg::cell_ctrl_t ctrl;
  mcs_pkg::entry_t    head;

  logic accept, store, out_free, term, emit;
  logic signed [31:0] coef;
  logic signed [63:0] v64;

  assign s_tready = (state == ST_LOAD);
  assign accept   = s_tvalid && s_tready;
  assign store    = accept && (count < FULL);
  assign out_free = !m_tvalid || m_tready;
  assign emit     = out_free && (((state == ST_P2) && term) || (state == ST_SUM));

  assign new_entry.valid = 1'b1;
  assign new_entry.pos   = count;
  assign new_entry.thr   = s_tdata[31:0];
  assign new_entry.idx   = s_tdata[41:32];
  assign new_entry.z     = s_tdata[58:42];

  assign ctrl.load   = store;
  assign ctrl.rotate = (state == ST_P1) || ((state == ST_P2) && out_free);
  assign ctrl.clear  = (state == ST_SUM) && out_free;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
      localparam int UP = (gi == 0) ? 0 : gi - 1;
      localparam int DN = (gi + 1) % MAX_ITEMS;
      mcs_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .new_entry  (new_entry),
        .up_entry   (cells[UP]),
        .up_before  ((gi == 0) ? 1'b0 : bef[UP]),
        .down_entry (cells[DN]),
        .entry      (cells[gi]),
        .ahead      (bef[gi])
      );
    end
  endgenerate

  assign head = cells[0];
  assign term = head.valid && (m != '0) && (head.pos < m);
  assign coef = mcs_pkg::sat33({thr_m[31], thr_m} - {head.thr[31], head.thr});
  assign v64  = diff_d >>> 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      cnt      <= '0;
      count    <= '0;
      tol      <= mcs_pkg::TOL_W'(1);
      t1_v     <= 1'b0;
      t2_v     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        tol <= cfg_wdata;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      // product and sum pipeline for the first rotation
      t1_v   <= (state == ST_P1) && term;
      t2_v   <= t1_v;
      prod_r <= coef_r * $signed({1'b0, z_r});
      if (t1_v) begin
        rhs <= rhs + 64'(coef_r);
      end
      if (t2_v) begin
        lhs <= lhs + 64'(prod_r);
      end
      case (state)
        ST_LOAD: begin
          if (store) begin
            count <= count + 1'b1;
            thrp  <= new_entry.thr;
            if (count == '0) begin
              thr0 <= new_entry.thr;
            end
          end
          if (accept && s_tlast) begin
            y     <= s_tdata[90:59];
            p     <= store ? count : count - 1'b1;
            m     <= store ? count : count - 1'b1;
            thr_m <= store ? new_entry.thr : thrp;
            lhs   <= '0;
            rhs   <= (store && count == '0) ? 64'(new_entry.thr) : 64'(thr0);
            cnt   <= '0;
            state <= ST_P1;
          end
        end
        ST_P1: begin
          if (term) begin
            coef_r <= coef;
            z_r    <= head.z;
            m      <= head.pos;
            thr_m  <= head.thr;
          end
          if (cnt == LAST_STEP) begin
            cnt   <= '0;
            state <= ST_DRAIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DRAIN: begin
          cnt <= cnt + 1'b1;
          if (cnt == mcs_pkg::POS_W'(1)) begin
            state <= ST_D1;
          end
        end
        ST_D1: begin
          acc_a <= (64'(y) <<< 16) + lhs;
          state <= ST_D2;
        end
        ST_D2: begin
          diff_d <= acc_a - (rhs <<< 16);
          state  <= ST_D3;
        end
        ST_D3: begin
          found <= diff_d > $signed({32'd0, tol, 16'd0});
          viol  <= (v64[63:31] != '0) ? 32'sh7fff_ffff : v64[31:0];
          m     <= p;
          thr_m <= thrp;
          cnt   <= '0;
          state <= (diff_d > $signed({32'd0, tol, 16'd0})) ? ST_P2 : ST_SUM;
        end
        ST_P2: begin
          if (out_free) begin
            if (term) begin
              m_tuser  <= mcs_pkg::KIND_TERM;
              m_tlast  <= 1'b0;
              m_tdata  <= {5'd0, 32'd0, 32'd0, 1'b0, coef, head.idx};
              m        <= head.pos;
              thr_m    <= head.thr;
            end
            cnt <= cnt + 1'b1;
            if (cnt == LAST_STEP) begin
              state <= ST_SUM;
            end
          end
        end
        ST_SUM: begin
          if (out_free) begin
            m_tuser  <= mcs_pkg::KIND_SUMMARY;
            m_tlast  <= 1'b1;
            if (found) begin
              m_tdata <= {5'd0, viol, mcs_pkg::sat64(rhs), 1'b1, 32'd0,
                          mcs_pkg::INDEX_BITS'(0)};
            end else begin
              m_tdata <= '0;
            end
            count <= '0;
            state <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

[rtl/mcs_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for mixing_cut_separation, bound to the top level.
// Depends on nothing but the top level's ports.
module mcs_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [111:0] m_tdata,
  input logic         m_tuser,
  input logic         m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled transfer changed");

  a_last_summary: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == m_tuser))
    else $error("end of run not on summary");

  a_term_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[111:42] == '0))
    else $error("cut term carries summary fields");

  a_no_load_mid_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> !s_tready)
    else $error("input ready while terms pending");

endmodule

bind mixing_cut_separation mcs_checker u_mcs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
